>>> sv/bcmp_pkg.sv
package bcmp_pkg;

   localparam int unsigned MAX_N = 65536;
   localparam int IDX_W = $clog2(MAX_N);
   localparam int IN_W = 16;
   localparam int VAL_W = 30;
   localparam int PROD_W = 2 * VAL_W;
   localparam int MU_W = VAL_W + 1;
   localparam int RED_W = VAL_W + 2;

   localparam logic [VAL_W-1:0] PRIME_MOD = 30'd998244353;
   localparam logic [VAL_W-1:0] INV_EXP = PRIME_MOD - 30'd2;
   localparam int EXP_W = VAL_W;
   localparam int ROUND_W = $clog2(EXP_W);

   localparam longint unsigned BARRETT_MU_L = (64'd1 << PROD_W) / 64'(PRIME_MOD);
   localparam logic [MU_W-1:0] BARRETT_MU = MU_W'(BARRETT_MU_L);

   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_FILL,
      MOP_SQ1,
      MOP_ACC1,
      MOP_SQ2,
      MOP_ACC2,
      MOP_FIN1,
      MOP_FIN2
   } mul_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_NR,
      RD_R,
      RD_N
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       init;
      mul_op_type mul_op;
      rd_sel_type rd_sel;
      logic       load_trivial;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic trivial;
      logic fill_last;
   } status_type;

endpackage

>>> sv/bcmp_modmul.sv
module bcmp_modmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bcmp_pkg::VAL_W-1:0]     op_a,
   input  logic [bcmp_pkg::VAL_W-1:0]     op_b,
   input  bcmp_pkg::mul_op_type           op_in,
   output logic [bcmp_pkg::VAL_W-1:0]     product,
   output bcmp_pkg::mul_op_type           op_out,
   output logic                           busy
);

   bcmp_pkg::mul_op_type tag1_ff, tag2_ff, tag3_ff;

   logic [bcmp_pkg::PROD_W-1:0]   t_in, t_ff;
   logic [2*bcmp_pkg::MU_W-1:0]   q2_in, q2_ff;
   logic [bcmp_pkg::RED_W-1:0]    tlo1_ff, tlo2_ff;
   logic [bcmp_pkg::MU_W-1:0]     q3;
   logic [bcmp_pkg::RED_W-1:0]    qp_in, qp_ff;
   logic [bcmp_pkg::RED_W-1:0]    rem;
   logic [bcmp_pkg::RED_W:0]      sub1, sub2;

   assign t_in  = op_a * op_b;
   assign q2_in = t_ff[bcmp_pkg::PROD_W-1:bcmp_pkg::VAL_W-1] * bcmp_pkg::BARRETT_MU;
   assign q3    = q2_ff[2*bcmp_pkg::MU_W-1:bcmp_pkg::VAL_W+1];
   assign qp_in = bcmp_pkg::RED_W'(q3) * bcmp_pkg::RED_W'(bcmp_pkg::PRIME_MOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= bcmp_pkg::MOP_NONE;
         tag2_ff <= bcmp_pkg::MOP_NONE;
         tag3_ff <= bcmp_pkg::MOP_NONE;
      end else begin
         tag1_ff <= op_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      q2_ff   <= q2_in;
      tlo1_ff <= t_ff[bcmp_pkg::RED_W-1:0];
      qp_ff   <= qp_in;
      tlo2_ff <= tlo1_ff;
   end

   // remainder lies below three times the modulus
   assign rem  = tlo2_ff - qp_ff;
   assign sub1 = {1'b0, rem} - {3'b000, bcmp_pkg::PRIME_MOD};
   assign sub2 = {1'b0, rem} - {2'b00, bcmp_pkg::PRIME_MOD, 1'b0};

   always_comb begin
      if (!sub2[bcmp_pkg::RED_W]) begin
         product = sub2[bcmp_pkg::VAL_W-1:0];
      end else if (!sub1[bcmp_pkg::RED_W]) begin
         product = sub1[bcmp_pkg::VAL_W-1:0];
      end else begin
         product = rem[bcmp_pkg::VAL_W-1:0];
      end
   end

   assign op_out = tag3_ff;
   assign busy   = (tag1_ff != bcmp_pkg::MOP_NONE) || (tag2_ff != bcmp_pkg::MOP_NONE) ||
                   (tag3_ff != bcmp_pkg::MOP_NONE);

endmodule

>>> sv/bcmp_datapath.sv
module bcmp_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bcmp_pkg::IN_W-1:0]    req_n_value,
   input  logic [bcmp_pkg::IN_W-1:0]    req_r_value,
   input  bcmp_pkg::cmd_type            cmd,
   output bcmp_pkg::status_type         status,
   output logic [bcmp_pkg::VAL_W-1:0]   rsp_coefficient
);

   logic [bcmp_pkg::VAL_W-1:0] fact_mem [bcmp_pkg::MAX_N];

   logic [bcmp_pkg::IN_W-1:0]  n_ff, r_ff;
   logic [bcmp_pkg::VAL_W-1:0] base1_ff, acc1_ff, base2_ff, acc2_ff;
   logic [bcmp_pkg::VAL_W-1:0] factn_ff, fin_ff, prod_ff, mem_rd_ff, rsp_coefficient_ff;
   logic [bcmp_pkg::IDX_W-1:0] fill_idx_ff;
   bcmp_pkg::rd_sel_type       rd_sel_ff;

   logic [bcmp_pkg::VAL_W-1:0] op_a, op_b, product;
   bcmp_pkg::mul_op_type       wb_op;
   logic                       mul_busy;

   logic [bcmp_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic [bcmp_pkg::VAL_W-1:0] wr_data;
   logic                       wr_en;

   always_comb begin
      unique case (cmd.mul_op)
         bcmp_pkg::MOP_FILL: begin
            op_a = prod_ff;
            op_b = bcmp_pkg::VAL_W'(fill_idx_ff);
         end
         bcmp_pkg::MOP_SQ1: begin
            op_a = base1_ff;
            op_b = base1_ff;
         end
         bcmp_pkg::MOP_ACC1: begin
            op_a = acc1_ff;
            op_b = base1_ff;
         end
         bcmp_pkg::MOP_SQ2: begin
            op_a = base2_ff;
            op_b = base2_ff;
         end
         bcmp_pkg::MOP_ACC2: begin
            op_a = acc2_ff;
            op_b = base2_ff;
         end
         bcmp_pkg::MOP_FIN1: begin
            op_a = factn_ff;
            op_b = acc1_ff;
         end
         bcmp_pkg::MOP_FIN2: begin
            op_a = fin_ff;
            op_b = acc2_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   bcmp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .op_a    (op_a),
      .op_b    (op_b),
      .op_in   (cmd.mul_op),
      .product (product),
      .op_out  (wb_op),
      .busy    (mul_busy)
   );

   always_comb begin
      unique case (cmd.rd_sel)
         bcmp_pkg::RD_NR: rd_addr = bcmp_pkg::IDX_W'(n_ff - r_ff);
         bcmp_pkg::RD_R:  rd_addr = bcmp_pkg::IDX_W'(r_ff);
         bcmp_pkg::RD_N:  rd_addr = bcmp_pkg::IDX_W'(n_ff);
         default:         rd_addr = '0;
      endcase
   end

   assign wr_en   = cmd.init || (wb_op == bcmp_pkg::MOP_FILL);
   assign wr_addr = cmd.init ? '0 : fill_idx_ff;
   assign wr_data = cmd.init ? bcmp_pkg::VAL_W'(1) : product;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fact_mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= fact_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_sel_ff   <= bcmp_pkg::RD_NONE;
         fill_idx_ff <= '0;
      end else begin
         rd_sel_ff <= cmd.rd_sel;
         if (cmd.init) begin
            fill_idx_ff <= bcmp_pkg::IDX_W'(1);
         end else if (wb_op == bcmp_pkg::MOP_FILL) begin
            fill_idx_ff <= fill_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         n_ff <= req_n_value;
         r_ff <= req_r_value;
      end
      if (cmd.init) begin
         prod_ff <= bcmp_pkg::VAL_W'(1);
      end
      unique case (rd_sel_ff)
         bcmp_pkg::RD_NR: begin
            base1_ff <= mem_rd_ff;
            acc1_ff  <= bcmp_pkg::VAL_W'(1);
         end
         bcmp_pkg::RD_R: begin
            base2_ff <= mem_rd_ff;
            acc2_ff  <= bcmp_pkg::VAL_W'(1);
         end
         bcmp_pkg::RD_N: begin
            factn_ff <= mem_rd_ff;
         end
         default: begin
         end
      endcase
      if (cmd.load_trivial) begin
         fin_ff <= (r_ff == n_ff) ? bcmp_pkg::VAL_W'(1) : '0;
      end
      case (wb_op)
         bcmp_pkg::MOP_FILL: prod_ff  <= product;
         bcmp_pkg::MOP_SQ1:  base1_ff <= product;
         bcmp_pkg::MOP_ACC1: acc1_ff  <= product;
         bcmp_pkg::MOP_SQ2:  base2_ff <= product;
         bcmp_pkg::MOP_ACC2: acc2_ff  <= product;
         bcmp_pkg::MOP_FIN1: fin_ff   <= product;
         bcmp_pkg::MOP_FIN2: fin_ff   <= product;
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_coefficient_ff <= fin_ff;
      end
   end

   assign status.busy      = mul_busy;
   assign status.trivial   = (r_ff >= n_ff) || (32'(n_ff) >= bcmp_pkg::MAX_N);
   assign status.fill_last = (wb_op == bcmp_pkg::MOP_FILL) &&
                             (fill_idx_ff == bcmp_pkg::IDX_W'(bcmp_pkg::MAX_N - 1));
   assign rsp_coefficient  = rsp_coefficient_ff;

endmodule

>>> sv/bcmp_ctrl.sv
module bcmp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bcmp_pkg::status_type  status,
   output bcmp_pkg::cmd_type     cmd
);

   typedef enum logic [10:0] {
      S_INIT  = 11'b00000000001,
      S_FILL  = 11'b00000000010,
      S_IDLE  = 11'b00000000100,
      S_CHECK = 11'b00000001000,
      S_RD_R  = 11'b00000010000,
      S_RD_N  = 11'b00000100000,
      S_POW   = 11'b00001000000,
      S_DRAIN = 11'b00010000000,
      S_FIN2  = 11'b00100000000,
      S_WAIT  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [1:0]                   slot_ff, slot_in;
   logic [bcmp_pkg::ROUND_W-1:0] round_ff, round_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         exp_bit;

   assign exp_bit = bcmp_pkg::INV_EXP[round_ff];

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      round_in      = round_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_op    = bcmp_pkg::MOP_NONE;
      cmd.rd_sel    = bcmp_pkg::RD_NONE;
      unique case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_FILL;
         end
         S_FILL: begin
            if (!status.busy) begin
               cmd.mul_op = bcmp_pkg::MOP_FILL;
            end
            if (status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.trivial) begin
               cmd.load_trivial = 1'b1;
               state_in         = S_DONE;
            end else begin
               cmd.rd_sel = bcmp_pkg::RD_NR;
               state_in   = S_RD_R;
            end
         end
         S_RD_R: begin
            cmd.rd_sel = bcmp_pkg::RD_R;
            state_in   = S_RD_N;
         end
         S_RD_N: begin
            cmd.rd_sel = bcmp_pkg::RD_N;
            slot_in    = '0;
            round_in   = '0;
            state_in   = S_POW;
         end
         S_POW: begin
            case (slot_ff)
               2'd0: cmd.mul_op = bcmp_pkg::MOP_SQ1;
               2'd1: cmd.mul_op = exp_bit ? bcmp_pkg::MOP_ACC1 : bcmp_pkg::MOP_NONE;
               2'd2: cmd.mul_op = bcmp_pkg::MOP_SQ2;
               default: cmd.mul_op = exp_bit ? bcmp_pkg::MOP_ACC2 : bcmp_pkg::MOP_NONE;
            endcase
            slot_in = slot_ff + 1'b1;
            if (slot_ff == 2'd3) begin
               round_in = round_ff + 1'b1;
               if (round_ff == bcmp_pkg::ROUND_W'(bcmp_pkg::EXP_W - 1)) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!status.busy) begin
               cmd.mul_op = bcmp_pkg::MOP_FIN1;
               state_in   = S_FIN2;
            end
         end
         S_FIN2: begin
            if (!status.busy) begin
               cmd.mul_op = bcmp_pkg::MOP_FIN2;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!status.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         slot_ff      <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/binomial_coefficient_mod_prime_unit.sv
// One query at a time. For r >= n or n beyond the table the result is set directly;
// otherwise the shared pipelined modular multiplier computes it, running the two Fermat
// inversions interleaved (30 exponent rounds of 4 issue slots each).
// After reset the factorial table fills one entry at a time, each product written back
// before the next is issued; req_ready stays low until the fill is done.
// A new query is taken while the previous result beat still waits on rsp_ready.
module binomial_coefficient_mod_prime_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bcmp_pkg::IN_W-1:0]   req_n_value,
   input  logic [bcmp_pkg::IN_W-1:0]   req_r_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bcmp_pkg::VAL_W-1:0]  rsp_coefficient
);

   bcmp_pkg::cmd_type    cmd;
   bcmp_pkg::status_type status;

   bcmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcmp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_n_value     (req_n_value),
      .req_r_value     (req_r_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_coefficient (rsp_coefficient)
   );

   assert property (@(posedge clock) disable iff (reset) req_ready |-> !status.busy)
      else $error("query taken with multiplier still busy");

   assert property (@(posedge clock) disable iff (reset) status.fill_last |=> req_ready)
      else $error("not ready after factorial fill");

   assert property (@(posedge clock) disable iff (reset)
                    cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result beat overwritten before taken");

endmodule
